// File: hw/rtl/delta_sign_magnitude_bit_packer_defines.svh
// Assertion macros for the delta sign-magnitude bit packer.
// No dependencies; included by the checker file.
`ifndef DELTA_SIGN_MAGNITUDE_BIT_PACKER_DEFINES_SVH
`define DELTA_SIGN_MAGNITUDE_BIT_PACKER_DEFINES_SVH

// Property checked on every clock edge, switched off while reset is high.
`define DSMBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define DSMBP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dsmbp_pkg.sv
// Shared types and constants of the delta sign-magnitude bit packer.
// No dependencies; used by every other file of the block but the defines header.
package dsmbp_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned MaxBytes   = 4;
   localparam int unsigned SampleBits = 16;
   localparam int unsigned MaxRawBits = 32;
   localparam int unsigned NarrowBits = 16;
   localparam logic [WordWidth-1:0] MagLimit = 32'h0000_7FFF;

   localparam logic [1:0] OP_RAW    = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_DIRECT = 2'd3;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_WIDTH    = 2'd1;
   localparam logic [1:0] ERR_TOO_WIDE = 2'd2;
   localparam logic [1:0] ERR_DELTA    = 2'd3;

   typedef struct packed {
      logic [1:0]                  op;
      logic [WordWidth-1:0]        raw_bits;
      logic [CountWidth-1:0]       bit_count;
      logic signed [WordWidth-1:0] sample;
      logic                        first_sample;
   } req_payload_type;

   // Bytes are left-aligned: the first byte to send sits in the top eight bits.
   typedef struct packed {
      logic [WordWidth-1:0] bytes;
      logic [2:0]           count;
      logic [1:0]           error_code;
   } pack_result_type;

endpackage

// File: hw/rtl/dsmbp_req_if.sv
// Request channel of the bit packer: valid/ready handshake and payload.
// Depends on dsmbp_pkg for field widths.
interface dsmbp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            op;
   logic [dsmbp_pkg::WordWidth-1:0]       raw_bits;
   logic [dsmbp_pkg::CountWidth-1:0]      bit_count;
   logic signed [dsmbp_pkg::WordWidth-1:0] sample;
   logic                                  first_sample;

   modport source (output valid, op, raw_bits, bit_count, sample, first_sample, input ready);
   modport sink (input valid, op, raw_bits, bit_count, sample, first_sample, output ready);
endinterface

// File: hw/rtl/dsmbp_rsp_if.sv
// Response channel of the bit packer: valid/ready handshake and one byte.
// Depends on dsmbp_pkg for field widths.
interface dsmbp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dsmbp_pkg::ByteWidth-1:0]    out_byte;
   logic                               last_of_run;
   logic [1:0]                         error_code;

   modport source (output valid, out_byte, last_of_run, error_code, input ready);
   modport sink (input valid, out_byte, last_of_run, error_code, output ready);
endinterface

// File: hw/rtl/delta_sign_magnitude_bit_packer.sv
// Top level of the delta sign-magnitude bit packer.
// Depends on dsmbp_pkg, dsmbp_req_if, dsmbp_rsp_if, dsmbp_pack and dsmbp_emit.
//
//   Channel   Direction   Carries
//   req_bus   in          op, raw_bits, bit_count, sample, first_sample
//   rsp_bus   out         out_byte, last_of_run, error_code (one byte per transfer)
//
// A request is registered on acceptance and leaves the input register once the burst
// buffer is empty or sending its last byte; its first byte is offered in the cycle
// after that. Bytes go out one per cycle while the response side is ready, and a request
// yields up to four bytes, or none; the burst buffer sets the rate.
// Reset is synchronous and active high; it clears pending bits, the previous sample
// and both register stages. A response stall holds the current byte and fills the
// input register, after which request ready drops.
module delta_sign_magnitude_bit_packer (
   input  logic        clock,
   input  logic        reset,
   dsmbp_req_if.sink   req_bus,
   dsmbp_rsp_if.source rsp_bus
);

   // Input register. It frees up in the same cycle that its request is packed,
   // so single-byte requests flow at one per cycle while the response side takes every byte.
   logic                       in_valid_ff, in_valid_in;
   dsmbp_pkg::req_payload_type in_payload_ff;
   dsmbp_pkg::pack_result_type pack_result;
   logic                       can_load;
   logic                       in_take;
   logic                       req_accept;

   assign in_take        = in_valid_ff && can_load;
   assign req_bus.ready  = !in_valid_ff || in_take;
   assign req_accept     = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_payload_ff.op           <= req_bus.op;
         in_payload_ff.raw_bits     <= req_bus.raw_bits;
         in_payload_ff.bit_count    <= req_bus.bit_count;
         in_payload_ff.sample       <= req_bus.sample;
         in_payload_ff.first_sample <= req_bus.first_sample;
      end
   end

   // The packer state advances only when a request leaves the input register.
   dsmbp_pack u_pack (
      .clock  (clock),
      .reset  (reset),
      .commit (in_take),
      .req    (in_payload_ff),
      .result (pack_result)
   );

   // A request with no bytes loads a zero count, which leaves the buffer empty.
   dsmbp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (in_take),
      .result   (pack_result),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule

// File: hw/rtl/dsmbp_pack.sv
// Packing logic and packer state (pending bits, previous sample).
// Depends on dsmbp_pkg.
module dsmbp_pack (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       commit,
   input  dsmbp_pkg::req_payload_type req,
   output dsmbp_pkg::pack_result_type result
);

   logic [6:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]  pend_count_ff, pend_count_in;
   logic [31:0] prev_sample_ff, prev_sample_in;

   logic [31:0] value;
   logic        neg;
   logic [31:0] mag;
   logic        delta_bad;
   logic        width_bad;
   logic        too_wide;
   logic [31:0] raw_mask;
   logic [31:0] pack_val;
   logic [5:0]  pack_n;
   logic [39:0] acc;
   logic [5:0]  cnt;
   logic [39:0] aligned;
   logic [6:0]  leftover;
   logic [7:0]  flush_byte;

   // Sample value and its sign-magnitude form.
   assign value     = req.first_sample ? req.sample : (req.sample - prev_sample_ff);
   assign neg       = value[31];
   assign mag       = neg ? (32'd0 - value) : value;
   assign delta_bad = mag > dsmbp_pkg::MagLimit;

   assign width_bad = (req.bit_count == '0) ||
                      (req.bit_count > 6'(dsmbp_pkg::MaxRawBits));
   assign raw_mask  = ~(32'hFFFF_FFFF << req.bit_count);
   assign too_wide  = (req.bit_count < 6'(dsmbp_pkg::NarrowBits)) &&
                      ((req.raw_bits & ~raw_mask) != '0);

   assign pack_n   = (req.op == dsmbp_pkg::OP_SAMPLE) ? 6'(dsmbp_pkg::SampleBits)
                                                      : req.bit_count;
   assign pack_val = (req.op == dsmbp_pkg::OP_SAMPLE) ? {16'd0, neg, mag[14:0]}
                                                      : (req.raw_bits & raw_mask);

   // Accumulate pending bits ahead of the new ones, then left-align at 40 bits.
   assign acc      = ({33'd0, pend_bits_ff} << pack_n) | {8'd0, pack_val};
   assign cnt      = {3'd0, pend_count_ff} + pack_n;
   assign aligned  = acc << (6'd40 - cnt);
   assign leftover = acc[6:0] & ~(7'h7F << cnt[2:0]);

   assign flush_byte = {1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_count_ff});

   always_comb begin
      result         = '0;
      pend_bits_in   = pend_bits_ff;
      pend_count_in  = pend_count_ff;
      prev_sample_in = prev_sample_ff;
      case (req.op)
         dsmbp_pkg::OP_RAW: begin
            if (width_bad) begin
               result.count      = 3'd1;
               result.error_code = dsmbp_pkg::ERR_WIDTH;
            end else if (too_wide) begin
               result.count      = 3'd1;
               result.error_code = dsmbp_pkg::ERR_TOO_WIDE;
            end else begin
               result.bytes  = aligned[39:8];
               result.count  = cnt[5:3];
               pend_bits_in  = leftover;
               pend_count_in = cnt[2:0];
            end
         end
         dsmbp_pkg::OP_SAMPLE: begin
            if (delta_bad) begin
               result.count      = 3'd1;
               result.error_code = dsmbp_pkg::ERR_DELTA;
            end else begin
               result.bytes   = aligned[39:8];
               result.count   = cnt[5:3];
               pend_bits_in   = leftover;
               pend_count_in  = cnt[2:0];
               prev_sample_in = req.sample;
            end
         end
         dsmbp_pkg::OP_FLUSH: begin
            if (pend_count_ff != '0) begin
               result.bytes  = {flush_byte, 24'd0};
               result.count  = 3'd1;
               pend_bits_in  = '0;
               pend_count_in = '0;
            end
         end
         default: begin
            result.bytes = req.raw_bits;
            result.count = 3'(dsmbp_pkg::MaxBytes);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff   <= '0;
         pend_count_ff  <= '0;
         prev_sample_ff <= '0;
      end else if (commit) begin
         pend_bits_ff   <= pend_bits_in;
         pend_count_ff  <= pend_count_in;
         prev_sample_ff <= prev_sample_in;
      end
   end

endmodule

// File: hw/rtl/dsmbp_emit.sv
// Burst buffer: holds up to four bytes and sends them one per cycle while the response side is ready.
// Depends on dsmbp_pkg and dsmbp_rsp_if.
module dsmbp_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  dsmbp_pkg::pack_result_type result,
   output logic                       can_load,
   dsmbp_rsp_if.source                rsp
);

   logic [2:0]  remain_ff, remain_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [1:0]  err_ff, err_in;
   logic        pop;

   assign pop      = (remain_ff != '0) && rsp.ready;
   assign can_load = (remain_ff == '0) || ((remain_ff == 3'd1) && rsp.ready);

   always_comb begin
      remain_in = remain_ff;
      bytes_in  = bytes_ff;
      err_in    = err_ff;
      if (load) begin
         remain_in = result.count;
         bytes_in  = result.bytes;
         err_in    = result.error_code;
      end else if (pop) begin
         remain_in = remain_ff - 3'd1;
         bytes_in  = {bytes_ff[23:0], 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
      bytes_ff <= bytes_in;
      err_ff   <= err_in;
   end

   assign rsp.valid       = remain_ff != '0;
   assign rsp.out_byte    = bytes_ff[31:24];
   assign rsp.last_of_run = remain_ff == 3'd1;
   assign rsp.error_code  = err_ff;

endmodule

// File: hw/rtl/dsmbp_checker.sv
// Port-level checks of the delta sign-magnitude bit packer, bound to the top level.
// Depends on dsmbp_pkg and delta_sign_magnitude_bit_packer_defines.svh.
`include "delta_sign_magnitude_bit_packer_defines.svh"

module dsmbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic [1:0] rsp_error_code
);

   // An error is always a single response and so always ends its run.
   `DSMBP_ASSERT(a_error_is_last, clock, reset, rsp_valid && (rsp_error_code != dsmbp_pkg::ERR_OK) |-> rsp_last_of_run, "error response not marked last")

   // An error response carries a zero byte.
   `DSMBP_ASSERT(a_error_zero_byte, clock, reset, rsp_valid && (rsp_error_code != dsmbp_pkg::ERR_OK) |-> rsp_out_byte == 8'd0, "error response with nonzero byte")

   // Nothing is offered in the cycle after reset.
   `DSMBP_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid, "response valid right after reset")

   // A stalled response holds.
   `DSMBP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run) && $stable(rsp_error_code), "stalled response changed")

endmodule

bind delta_sign_magnitude_bit_packer dsmbp_checker u_dsmbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_last_of_run (rsp_bus.last_of_run),
   .rsp_error_code  (rsp_bus.error_code)
);

// File: tb/delta_sign_magnitude_bit_packer_tb.sv
// Self-checking testbench for the delta sign-magnitude bit packer.
// Depends on dsmbp_pkg, dsmbp_req_if, dsmbp_rsp_if and the packer top level.
`timescale 1ns / 1ps

module delta_sign_magnitude_bit_packer_tb;

   // One response byte as the packer should deliver it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic [1:0] error_code;
   } byte_result_type;

   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned DrainCycles   = 20;
   localparam int unsigned RandomCount   = 480;
   localparam int unsigned HoldOffCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsmbp_req_if req_bus();
   dsmbp_rsp_if rsp_bus();

   delta_sign_magnitude_bit_packer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and bytes the packer still owes us.
   dsmbp_pkg::req_payload_type pending_requests[$];
   byte_result_type            expected_bytes[$];

   // Our own copy of the packer state: leftover bits, their count, and the
   // last sample that was accepted into the bit stream.
   logic [6:0]  held_bits;
   logic [2:0]  held_count;
   logic [31:0] last_sample;

   int unsigned cycle_count       = 0;
   int unsigned mismatch_count    = 0;
   int unsigned requests_accepted = 0;
   int unsigned total_requests    = 0;
   logic        req_taken         = 1'b0;
   logic        hold_off          = 1'b0;
   logic        draining          = 1'b0;

   // Sender burst/gap bookkeeping and the receiver's stall pattern.
   int unsigned                burst_left = 1;
   int unsigned                gap_left   = 0;
   dsmbp_pkg::req_payload_type next_request;
   logic [7:0]                 stall_pattern = 8'hFF;
   logic [2:0]                 pattern_slot  = 3'd0;
   int unsigned                pattern_age   = 0;

   // The generator tracks the previous accepted sample so that most samples
   // are deltas that fit in 15 bits of magnitude.
   logic signed [31:0] gen_prev  = 32'sd0;
   int unsigned        run_left  = 0;

   function automatic void push_result(input logic [7:0] value, input logic last,
                                       input logic [1:0] code);
      byte_result_type res;
      res.out_byte    = value;
      res.last_of_run = last;
      res.error_code  = code;
      expected_bytes.push_back(res);
   endfunction

   // Append n bits (1..32) MSB first behind the held bits and emit every full
   // byte. The last byte emitted carries the end-of-run marker.
   function automatic void append_bits(input logic [31:0] value, input int unsigned n);
      logic [63:0] acc;
      logic [63:0] rest;
      int unsigned cnt;
      acc = ({57'd0, held_bits} << n) | ({32'd0, value} & ((64'd1 << n) - 64'd1));
      cnt = held_count + n;
      while (cnt >= 8) begin
         cnt = cnt - 8;
         push_result(8'(acc >> cnt), cnt < 8, dsmbp_pkg::ERR_OK);
      end
      rest       = acc & ((64'd1 << cnt) - 64'd1);
      held_bits  = rest[6:0];
      held_count = 3'(cnt);
   endfunction

   // Work out every byte that one accepted request produces.
   function automatic void predict_packed_bytes(input dsmbp_pkg::req_payload_type r);
      logic [31:0] value;
      logic [31:0] magnitude;
      logic        negative;
      case (r.op)
         dsmbp_pkg::OP_RAW: begin
            if (r.bit_count == 0 || r.bit_count > dsmbp_pkg::MaxRawBits)
               push_result(8'd0, 1'b1, dsmbp_pkg::ERR_WIDTH);
            else if (r.bit_count < dsmbp_pkg::NarrowBits &&
                     (r.raw_bits >> r.bit_count) != 0)
               push_result(8'd0, 1'b1, dsmbp_pkg::ERR_TOO_WIDE);
            else
               append_bits(r.raw_bits, r.bit_count);
         end
         dsmbp_pkg::OP_SAMPLE: begin
            value     = r.first_sample ? r.sample : r.sample - last_sample;
            negative  = value[31];
            magnitude = negative ? -value : value;
            if (magnitude > dsmbp_pkg::MagLimit) begin
               push_result(8'd0, 1'b1, dsmbp_pkg::ERR_DELTA);
            end else begin
               last_sample = r.sample;
               append_bits({16'd0, negative, magnitude[14:0]}, dsmbp_pkg::SampleBits);
            end
         end
         dsmbp_pkg::OP_FLUSH: begin
            if (held_count != 0) begin
               push_result({1'b0, held_bits} << (8 - held_count), 1'b1, dsmbp_pkg::ERR_OK);
               held_bits  = 7'd0;
               held_count = 3'd0;
            end
         end
         default: begin
            push_result(r.raw_bits[31:24], 1'b0, dsmbp_pkg::ERR_OK);
            push_result(r.raw_bits[23:16], 1'b0, dsmbp_pkg::ERR_OK);
            push_result(r.raw_bits[15:8], 1'b0, dsmbp_pkg::ERR_OK);
            push_result(r.raw_bits[7:0], 1'b1, dsmbp_pkg::ERR_OK);
         end
      endcase
   endfunction

   function automatic void add_request(input logic [1:0] op, input logic [31:0] raw,
                                       input logic [5:0] count, input logic [31:0] smp,
                                       input logic first);
      dsmbp_pkg::req_payload_type r;
      r.op           = op;
      r.raw_bits     = raw;
      r.bit_count    = count;
      r.sample       = smp;
      r.first_sample = first;
      pending_requests.push_back(r);
   endfunction

   // One random request. Most are well-formed: raw fields that fit, sample
   // runs that open with an absolute value and go on with small deltas.
   // The rest are flushes, direct words and malformed requests.
   function automatic void add_random_request();
      int unsigned        pick;
      int unsigned        n;
      int unsigned        w;
      logic [31:0]        raw;
      logic signed [31:0] delta;
      logic signed [31:0] smp;
      logic               first;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         n   = $urandom_range(1, 32);
         raw = $urandom;
         if (n < 16)
            raw = raw & ((32'd1 << n) - 32'd1);
         add_request(dsmbp_pkg::OP_RAW, raw, 6'(n), $urandom, 1'($urandom));
      end else if (pick < 68) begin
         first = (run_left == 0);
         if (first)
            run_left = $urandom_range(2, 20);
         else
            run_left = run_left - 1;
         w = $urandom_range(0, 15);
         delta = (w == 15) ? 32'sd32767 : 32'($urandom_range(0, (1 << w) - 1));
         // An occasional sample that lands just past the limit.
         if ($urandom_range(0, 19) == 0)
            delta = 32'sd32768 + 32'($urandom_range(0, 1000));
         if ($urandom_range(0, 1) == 1)
            delta = -delta;
         smp = first ? delta : gen_prev + delta;
         if (delta <= 32'sd32767 && delta >= -32'sd32767)
            gen_prev = smp;
         add_request(dsmbp_pkg::OP_SAMPLE, $urandom, 6'($urandom), smp, first);
      end else if (pick < 78) begin
         add_request(dsmbp_pkg::OP_FLUSH, $urandom, 6'($urandom), $urandom, 1'($urandom));
      end else if (pick < 88) begin
         add_request(dsmbp_pkg::OP_DIRECT, $urandom, 6'($urandom), $urandom, 1'($urandom));
      end else if (pick < 92) begin
         n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(33, 63);
         add_request(dsmbp_pkg::OP_RAW, $urandom, 6'(n), $urandom, 1'($urandom));
      end else if (pick < 96) begin
         n   = $urandom_range(1, 15);
         raw = $urandom | (32'd1 << $urandom_range(n, 31));
         add_request(dsmbp_pkg::OP_RAW, raw, 6'(n), $urandom, 1'($urandom));
      end else begin
         // A fully random sample is almost always too far from anything.
         add_request(dsmbp_pkg::OP_SAMPLE, $urandom, 6'($urandom), $urandom, 1'($urandom));
      end
   endfunction

   // Acceptance, prediction and response checking all happen at the rising
   // edge. Prediction runs first, but a byte can never leave in the same
   // cycle its request is taken, so the order only matters for readability.
   always @(posedge clock) begin : check_responses
      byte_result_type wanted;
      cycle_count = cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         req_taken <= !reset && req_bus.valid && req_bus.ready;
         if (!reset) begin
            if (req_bus.valid && req_bus.ready) begin
               requests_accepted = requests_accepted + 1;
               predict_packed_bytes({req_bus.op, req_bus.raw_bits, req_bus.bit_count,
                                     req_bus.sample, req_bus.first_sample});
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (expected_bytes.size() == 0) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("%0t: byte %h last %b err %0d arrived with nothing expected",
                              $realtime, rsp_bus.out_byte, rsp_bus.last_of_run,
                              rsp_bus.error_code);
               end else begin
                  wanted = expected_bytes.pop_front();
                  if (rsp_bus.out_byte !== wanted.out_byte ||
                      rsp_bus.last_of_run !== wanted.last_of_run ||
                      rsp_bus.error_code !== wanted.error_code) begin
                     mismatch_count = mismatch_count + 1;
                     if (mismatch_count <= 10)
                        $display("%0t: expected byte %h last %b err %0d, got %h %b %0d",
                                 $realtime, wanted.out_byte, wanted.last_of_run,
                                 wanted.error_code, rsp_bus.out_byte,
                                 rsp_bus.last_of_run, rsp_bus.error_code);
                  end
               end
            end
         end
      end
   end

   // Request driver. It works in bursts: a request is offered back to back
   // until the burst runs out, then valid drops for a random gap, which may be empty. Some bursts
   // are long so that stretches with no idling at all occur too. A request
   // stays on the bus untouched until the edge that takes it.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            req_bus.op           <= next_request.op;
            req_bus.raw_bits     <= next_request.raw_bits;
            req_bus.bit_count    <= next_request.bit_count;
            req_bus.sample       <= next_request.sample;
            req_bus.first_sample <= next_request.first_sample;
            req_bus.valid        <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure. The receiver walks the bits of a ready pattern that
   // is replaced when its random age runs out; a third of the patterns never stall.
   // The long hold-off and the final drain override the pattern.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(20, 80);
            if ($urandom_range(0, 2) == 0) begin
               stall_pattern = 8'hFF;
            end else begin
               stall_pattern = 8'($urandom);
               stall_pattern[$urandom_range(0, 7)] = 1'b1;
            end
         end else begin
            pattern_age = pattern_age - 1;
         end
         pattern_slot = pattern_slot + 3'd1;
         rsp_bus.ready <= draining || (!hold_off && stall_pattern[pattern_slot]);
      end
   end

   // Once the run is well under way the receiver stops taking bytes for a
   // long stretch. The sender keeps offering, so the packer's burst buffer
   // and input register fill and ready on the request side must drop.
   initial begin
      while (reset || requests_accepted < 150)
         @(posedge clock);
      hold_off = 1'b1;
      repeat (HoldOffCycles) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.op           = dsmbp_pkg::OP_RAW;
      req_bus.raw_bits     = 32'd0;
      req_bus.bit_count    = 6'd0;
      req_bus.sample       = 32'sd0;
      req_bus.first_sample = 1'b0;
      rsp_bus.ready        = 1'b0;
      held_bits            = 7'd0;
      held_count           = 3'd0;
      last_sample          = 32'd0;

      // Directed opening: field extremes, every operation and every error.
      add_request(dsmbp_pkg::OP_RAW, 32'd1, 6'd1, 32'd0, 1'b0);          // single bit
      add_request(dsmbp_pkg::OP_RAW, 32'hFFFF_FFFF, 6'd32, 32'd0, 1'b0); // full word
      add_request(dsmbp_pkg::OP_RAW, 32'h0000_7FFF, 6'd15, 32'd0, 1'b0); // widest narrow
      add_request(dsmbp_pkg::OP_RAW, 32'd0, 6'd0, 32'd0, 1'b0);          // zero width
      add_request(dsmbp_pkg::OP_RAW, 32'd0, 6'd63, 32'd0, 1'b0);         // largest bad width
      add_request(dsmbp_pkg::OP_RAW, 32'd0, 6'd33, 32'd0, 1'b0);         // just past 32
      add_request(dsmbp_pkg::OP_RAW, 32'd16, 6'd4, 32'd0, 1'b0);         // narrow overflow
      add_request(dsmbp_pkg::OP_RAW, 32'h0000_8000, 6'd15, 32'd0, 1'b0); // overflow at 15
      add_request(dsmbp_pkg::OP_RAW, 32'hFFFF_FFFF, 6'd16, 32'd0, 1'b0); // upper bits dropped
      add_request(dsmbp_pkg::OP_RAW, 32'd5, 6'd3, 32'd0, 1'b0);
      add_request(dsmbp_pkg::OP_FLUSH, 32'd0, 6'd0, 32'd0, 1'b0);        // flush with bits held
      add_request(dsmbp_pkg::OP_FLUSH, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1); // none held
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'sd0, 1'b1);      // zero sends 0x0000
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'sd32767, 1'b1);  // largest first sample
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'sd0, 1'b0);      // delta of -32767
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, -32'sd32768, 1'b0); // delta just too large
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'h8000_0000, 1'b1); // most negative
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'h7FFF_FFFF, 1'b1); // most positive
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, 32'sd100, 1'b0);    // delta from zero
      add_request(dsmbp_pkg::OP_RAW, 32'h1F, 6'd5, 32'd0, 1'b0);
      add_request(dsmbp_pkg::OP_SAMPLE, 32'd0, 6'd0, -32'sd5, 1'b1);     // negative absolute
      add_request(dsmbp_pkg::OP_DIRECT, 32'h1234_5678, 6'd0, 32'd0, 1'b0); // bypasses held bits
      add_request(dsmbp_pkg::OP_DIRECT, 32'd0, 6'd63, 32'hFFFF_FFFF, 1'b1);
      add_request(dsmbp_pkg::OP_FLUSH, 32'd0, 6'd0, 32'd0, 1'b0);

      repeat (RandomCount) add_random_request();
      total_requests = pending_requests.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (requests_accepted < total_requests || expected_bytes.size() != 0)
         @(posedge clock);

      // Give the packer time to show any byte it should not send.
      draining = 1'b1;
      repeat (DrainCycles) @(posedge clock);
      mismatch_count = mismatch_count + expected_bytes.size();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
